// File: sv/spe_pkg.sv
// Shared types, constants and constant functions of the sinusoidal position encoder.
`default_nettype none
package spe_pkg;

    localparam int MAX_SEQUENCE  = 65536;
    localparam int MAX_DIM       = 4096;
    localparam int OUT_FRAC_BITS = 15;

    localparam logic [11:0] HALF_DIM_RESET = 12'd256;
    localparam logic [11:0] HALF_DIM_MAX   = 12'(MAX_DIM / 2);
    localparam logic [15:0] POSITION_MAX   = 16'(MAX_SEQUENCE - 1);

    localparam logic [3:0]  LOG2_TENK_INT  = 4'd13;
    localparam logic [30:0] LOG2_TENK_FRAC = 31'd1235715261;
    localparam logic [63:0] TWO_PI_Q32     = 64'd26986075409;
    localparam logic [29:0] INV_TWO_PI_Q32 = 30'd683565276;
    localparam logic [31:0] ONE_Q30        = 32'h4000_0000;

    localparam logic signed [33:0] SIN_C1 = 34'sd1686629713;
    localparam logic signed [33:0] SIN_C3 = 34'sd693598668;
    localparam logic signed [33:0] SIN_C5 = 34'sd85569306;
    localparam logic signed [33:0] SIN_C7 = 34'sd5026782;
    localparam logic signed [33:0] SIN_C9 = 34'sd172265;

    localparam int RND_SH = 30 - OUT_FRAC_BITS;
    localparam logic [31:0] RND_HALF = 32'(64'd1 << (RND_SH - 1));
    localparam logic [31:0] OUT_MAX  =
        (((64'd1 << OUT_FRAC_BITS) - 64'd1) > 64'd32767) ? 32'd32767 :
        32'((64'd1 << OUT_FRAC_BITS) - 64'd1);

    localparam int DIV_CELLS = 32;
    localparam int EXP_CELLS = 32;
    localparam int MOD_CELLS = 15;

    // Item data that rides along the chain.
    typedef struct packed {
        logic [15:0] pos;
        logic [3:0]  shift;
        logic        err;
    } t_side;

    // One lane of the sine polynomial.
    typedef struct packed {
        logic signed [32:0] acc;
        logic [30:0]        z;
        logic [30:0]        z2;
        logic [1:0]         quad;
    } t_lane;

    function automatic logic [63:0] isqrt64(input logic [63:0] val);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] b;
        v   = val;
        res = 64'd0;
        for (int s = 31; s >= 0; s--) begin
            b = 64'd1 << (2 * s);
            if (v >= res + b) begin
                v   = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
        end
        return res;
    endfunction

    // 2^(-2^-idx) in Q0.32 by the truncating square-root chain.
    function automatic logic [31:0] chain_factor(input int idx);
        logic [63:0] c;
        c = 64'h8000_0000;
        for (int i = 1; i <= idx; i++) begin
            c = isqrt64(c << 32);
        end
        return c[31:0];
    endfunction

endpackage
`default_nettype wire

// File: sv/spe_div_cell.sv
// One restoring-division cell: produces one quotient bit of k / half_dim.
`default_nettype none
module spe_div_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  spe_pkg::t_side  i_side,
    input  logic [11:0]     i_divisor,
    input  logic [12:0]     i_rem,
    input  logic [31:0]     i_quot,
    output logic            o_valid,
    output spe_pkg::t_side  o_side,
    output logic [12:0]     o_rem,
    output logic [31:0]     o_quot
);
    logic           r_valid;
    spe_pkg::t_side r_side;
    logic [12:0]    r_rem,  n_rem;
    logic [31:0]    r_quot, n_quot;
    logic [13:0]    w_trial;
    logic           w_ge;

    always_comb begin
        w_trial = {i_rem, 1'b0};
        w_ge    = w_trial >= {2'b00, i_divisor};
        n_rem   = w_ge ? 13'(w_trial - {2'b00, i_divisor}) : w_trial[12:0];
        n_quot  = {i_quot[30:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side <= i_side;
            r_rem  <= n_rem;
            r_quot <= n_quot;
        end
    end

    assign o_valid = r_valid;
    assign o_side  = r_side;
    assign o_rem   = r_rem;
    assign o_quot  = r_quot;
endmodule
`default_nettype wire

// File: sv/spe_exp_cell.sv
// One cell of 2^-frac: multiply by a fixed root factor when its exponent bit is set.
`default_nettype none
module spe_exp_cell #(
    parameter int IDX = 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  spe_pkg::t_side  i_side,
    input  logic [31:0]     i_frac,
    input  logic [32:0]     i_prod,
    output logic            o_valid,
    output spe_pkg::t_side  o_side,
    output logic [31:0]     o_frac,
    output logic [32:0]     o_prod
);
    localparam logic [31:0] FACTOR = spe_pkg::chain_factor(IDX);

    logic           r_valid;
    spe_pkg::t_side r_side;
    logic [31:0]    r_frac;
    logic [32:0]    r_prod, n_prod;
    logic [64:0]    w_mul;

    always_comb begin
        w_mul  = {32'd0, i_prod} * {33'd0, FACTOR};
        n_prod = i_frac[32 - IDX] ? w_mul[64:32] : i_prod;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side <= i_side;
            r_frac <= i_frac;
            r_prod <= n_prod;
        end
    end

    assign o_valid = r_valid;
    assign o_side  = r_side;
    assign o_frac  = r_frac;
    assign o_prod  = r_prod;
endmodule
`default_nettype wire

// File: sv/spe_mod_cell.sv
// One cell of the reduction modulo 2*pi: subtract a shifted copy of 2*pi when it fits.
`default_nettype none
module spe_mod_cell #(
    parameter int SHIFT = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  spe_pkg::t_side  i_side,
    input  logic [48:0]     i_angle,
    output logic            o_valid,
    output spe_pkg::t_side  o_side,
    output logic [48:0]     o_angle
);
    localparam logic [63:0] STEP_WIDE = spe_pkg::TWO_PI_Q32 << SHIFT;
    localparam logic [48:0] STEP      = STEP_WIDE[48:0];

    logic           r_valid;
    spe_pkg::t_side r_side;
    logic [48:0]    r_angle, n_angle;

    always_comb begin
        n_angle = (i_angle >= STEP) ? i_angle - STEP : i_angle;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side  <= i_side;
            r_angle <= n_angle;
        end
    end

    assign o_valid = r_valid;
    assign o_side  = r_side;
    assign o_angle = r_angle;
endmodule
`default_nettype wire

// File: sv/spe_poly_cell.sv
// One Horner step of the quarter-wave sine polynomial, for the sine and cosine lanes.
`default_nettype none
module spe_poly_cell #(
    parameter logic signed [33:0] COEF  = 34'sd0,
    parameter bit                 USE_Z = 1'b0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  spe_pkg::t_side       i_side,
    input  spe_pkg::t_lane [1:0] i_lane,
    output logic                 o_valid,
    output spe_pkg::t_side       o_side,
    output spe_pkg::t_lane [1:0] o_lane
);
    logic                 r_valid;
    spe_pkg::t_side       r_side;
    spe_pkg::t_lane [1:0] r_lane, n_lane;
    logic [30:0]          w_mult [2];
    logic [32:0]          w_mag  [2];
    logic [62:0]          w_prod [2];
    logic signed [33:0]   w_term [2];
    logic signed [33:0]   w_sum  [2];

    // Signed times unsigned Q30, truncated toward zero, then add the coefficient.
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            w_mult[l] = USE_Z ? i_lane[l].z : i_lane[l].z2;
            w_mag[l]  = i_lane[l].acc[32] ? 33'(-i_lane[l].acc) : 33'(i_lane[l].acc);
            w_prod[l] = {31'd0, w_mag[l][31:0]} * {32'd0, w_mult[l]};
            w_term[l] = i_lane[l].acc[32] ? -$signed({1'b0, w_prod[l][62:30]})
                                          :  $signed({1'b0, w_prod[l][62:30]});
            w_sum[l]  = COEF + w_term[l];
            n_lane[l]      = i_lane[l];
            n_lane[l].acc  = w_sum[l][32:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side <= i_side;
            r_lane <= n_lane;
        end
    end

    assign o_valid = r_valid;
    assign o_side  = r_side;
    assign o_lane  = r_lane;
endmodule
`default_nettype wire

// File: sv/sinusoidal_position_encoder.sv
// Top level of the sinusoidal position encoder: cell chains, glue stages and output buffer.
// Usage: present a token position and a pair index k on the input channel
// (i_valid / o_ready); the block returns sin and cos of position * 10000^(-k/half_dim)
// in signed Q1.15 on the output channel (o_valid / i_ready). A pair index not below
// half_dim returns index_error with both values zero. The user must see that half_dim
// is written through i_cfg_we / i_cfg_data only while the block is idle; the block does
// not enforce it. Values above 2048 act as 2048, zero marks every pair index out of range.
// Pipeline from acceptance to o_valid: 32 division cells (one quotient bit each), one
// exponent stage, 32 root-factor cells, one position multiply, 15 modulo cells, one
// phase multiply, one squaring stage, 5 polynomial cells, output register.
// Throughput: one item per cycle when not stalled; the whole chain advances together.
// Stalls: the output register is backed by a one-item skid buffer. While the receiver
// holds i_ready low, the chain keeps accepting until the skid buffer fills, then
// o_ready drops and every cell holds. Nothing is lost or repeated.
// Reset: synchronous, active low; clears all valid bits and the buffer, and sets
// half_dim to 256. No clearing pass is needed.
`default_nettype none
module sinusoidal_position_encoder (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [15:0]        i_position,
    input  logic [10:0]        i_pair_index,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [15:0] o_sin_value,
    output logic signed [15:0] o_cos_value,
    output logic               o_index_error,
    input  logic               i_cfg_we,
    input  logic [11:0]        i_cfg_data
);
    localparam int ND = spe_pkg::DIV_CELLS;
    localparam int NE = spe_pkg::EXP_CELLS;
    localparam int NM = spe_pkg::MOD_CELLS;
    localparam int NP = 5;

    logic [11:0] r_half_dim;
    logic [11:0] w_hdim;
    logic        w_en;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_dim <= spe_pkg::HALF_DIM_RESET;
        end else if (i_cfg_we) begin
            r_half_dim <= i_cfg_data;
        end
    end

    assign w_hdim = (r_half_dim > spe_pkg::HALF_DIM_MAX) ? spe_pkg::HALF_DIM_MAX : r_half_dim;

    // Division chain.
    logic           w_dv    [ND + 1];
    spe_pkg::t_side w_dside [ND + 1];
    logic [12:0]    w_drem  [ND + 1];
    logic [31:0]    w_dquot [ND + 1];

    always_comb begin
        w_dv[0]          = i_valid;
        w_dside[0].pos   = (i_position > spe_pkg::POSITION_MAX) ? spe_pkg::POSITION_MAX
                                                                : i_position;
        w_dside[0].shift = 4'd0;
        w_dside[0].err   = {1'b0, i_pair_index} >= w_hdim;
        w_drem[0]        = {2'b00, i_pair_index};
        w_dquot[0]       = 32'd0;
    end

    for (genvar g = 0; g < ND; g++) begin : g_div
        spe_div_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_en      (w_en),
            .i_valid   (w_dv[g]),
            .i_side    (w_dside[g]),
            .i_divisor (w_hdim),
            .i_rem     (w_drem[g]),
            .i_quot    (w_dquot[g]),
            .o_valid   (w_dv[g + 1]),
            .o_side    (w_dside[g + 1]),
            .o_rem     (w_drem[g + 1]),
            .o_quot    (w_dquot[g + 1])
        );
    end

    // Exponent stage: x = r * log2(10000), split into shift and fraction.
    logic           r_x_valid;
    spe_pkg::t_side r_x_side;
    logic [31:0]    r_x_frac;
    logic [62:0]    w_x_fmul;
    logic [35:0]    w_x;

    always_comb begin
        w_x_fmul = {31'd0, w_dquot[ND]} * {32'd0, spe_pkg::LOG2_TENK_FRAC};
        w_x      = 36'({4'd0, w_dquot[ND]} * {32'd0, spe_pkg::LOG2_TENK_INT})
                 + {5'd0, w_x_fmul[62:32]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_valid <= 1'b0;
        end else if (w_en) begin
            r_x_valid <= w_dv[ND];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_x_side <= {w_dside[ND].pos, w_x[35:32], w_dside[ND].err};
            r_x_frac <= w_x[31:0];
        end
    end

    // Root-factor chain for 2^-frac.
    logic           w_ev    [NE + 1];
    spe_pkg::t_side w_eside [NE + 1];
    logic [31:0]    w_efrac [NE + 1];
    logic [32:0]    w_eprod [NE + 1];

    always_comb begin
        w_ev[0]    = r_x_valid;
        w_eside[0] = r_x_side;
        w_efrac[0] = r_x_frac;
        w_eprod[0] = 33'h1_0000_0000;
    end

    for (genvar g = 0; g < NE; g++) begin : g_exp
        spe_exp_cell #(.IDX(g + 1)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_ev[g]),
            .i_side  (w_eside[g]),
            .i_frac  (w_efrac[g]),
            .i_prod  (w_eprod[g]),
            .o_valid (w_ev[g + 1]),
            .o_side  (w_eside[g + 1]),
            .o_frac  (w_efrac[g + 1]),
            .o_prod  (w_eprod[g + 1])
        );
    end

    // Angle stage: position times frequency, shifted by the integer exponent.
    logic           r_a_valid;
    spe_pkg::t_side r_a_side;
    logic [48:0]    r_a_angle;
    logic [48:0]    w_a_mul;

    assign w_a_mul = {33'd0, w_eside[NE].pos} * {16'd0, w_eprod[NE]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_en) begin
            r_a_valid <= w_ev[NE];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_side  <= w_eside[NE];
            r_a_angle <= w_a_mul >> w_eside[NE].shift;
        end
    end

    // Modulo 2*pi chain, largest multiple first.
    logic           w_mv    [NM + 1];
    spe_pkg::t_side w_mside [NM + 1];
    logic [48:0]    w_mang  [NM + 1];

    always_comb begin
        w_mv[0]    = r_a_valid;
        w_mside[0] = r_a_side;
        w_mang[0]  = r_a_angle;
    end

    for (genvar g = 0; g < NM; g++) begin : g_mod
        spe_mod_cell #(.SHIFT(NM - 1 - g)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_mv[g]),
            .i_side  (w_mside[g]),
            .i_angle (w_mang[g]),
            .o_valid (w_mv[g + 1]),
            .o_side  (w_mside[g + 1]),
            .o_angle (w_mang[g + 1])
        );
    end

    // Phase stage: radians to turns.
    logic           r_u_valid;
    spe_pkg::t_side r_u_side;
    logic [31:0]    r_u_phase;
    logic [61:0]    w_u_mul;

    assign w_u_mul = {30'd0, w_mang[NM][34:3]} * {32'd0, spe_pkg::INV_TWO_PI_Q32};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_u_valid <= 1'b0;
        end else if (w_en) begin
            r_u_valid <= w_mv[NM];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_u_side  <= w_mside[NM];
            r_u_phase <= w_u_mul[60:29];
        end
    end

    // Squaring stage: quadrant fold and z^2 for both lanes; cosine is a quarter turn ahead.
    logic                 r_q_valid;
    spe_pkg::t_side       r_q_side;
    spe_pkg::t_lane [1:0] r_q_lane, n_q_lane;
    logic [31:0]          w_q_ph [2];
    logic [30:0]          w_q_z  [2];
    logic [61:0]          w_q_sq [2];

    always_comb begin
        w_q_ph[0] = r_u_phase;
        w_q_ph[1] = r_u_phase + spe_pkg::ONE_Q30;
        for (int l = 0; l < 2; l++) begin
            w_q_z[l]  = w_q_ph[l][30] ? 31'(spe_pkg::ONE_Q30 - {2'b00, w_q_ph[l][29:0]})
                                      : {1'b0, w_q_ph[l][29:0]};
            w_q_sq[l] = {31'd0, w_q_z[l]} * {31'd0, w_q_z[l]};
            n_q_lane[l].acc  = spe_pkg::SIN_C9[32:0];
            n_q_lane[l].z    = w_q_z[l];
            n_q_lane[l].z2   = w_q_sq[l][60:30];
            n_q_lane[l].quad = w_q_ph[l][31:30];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_valid <= 1'b0;
        end else if (w_en) begin
            r_q_valid <= r_u_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_q_side <= r_u_side;
            r_q_lane <= n_q_lane;
        end
    end

    // Polynomial chain.
    localparam logic signed [33:0] PCOEF [NP] = '{
        -spe_pkg::SIN_C7, spe_pkg::SIN_C5, -spe_pkg::SIN_C3, spe_pkg::SIN_C1, 34'sd0
    };

    logic                 w_pv    [NP + 1];
    spe_pkg::t_side       w_pside [NP + 1];
    spe_pkg::t_lane [1:0] w_plane [NP + 1];

    always_comb begin
        w_pv[0]    = r_q_valid;
        w_pside[0] = r_q_side;
        w_plane[0] = r_q_lane;
    end

    for (genvar g = 0; g < NP; g++) begin : g_poly
        spe_poly_cell #(.COEF(PCOEF[g]), .USE_Z(g == NP - 1)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_pv[g]),
            .i_side  (w_pside[g]),
            .i_lane  (w_plane[g]),
            .o_valid (w_pv[g + 1]),
            .o_side  (w_pside[g + 1]),
            .o_lane  (w_plane[g + 1])
        );
    end

    // Round, clip, sign.
    logic [31:0]        w_o_s   [2];
    logic [31:0]        w_o_r   [2];
    logic [15:0]        w_o_mag [2];
    logic signed [15:0] w_o_val [2];

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            w_o_s[l]   = w_plane[NP][l].acc[32] ? 32'd0 : w_plane[NP][l].acc[31:0];
            w_o_r[l]   = (w_o_s[l] + spe_pkg::RND_HALF) >> spe_pkg::RND_SH;
            w_o_mag[l] = (w_o_r[l] > spe_pkg::OUT_MAX) ? spe_pkg::OUT_MAX[15:0] : w_o_r[l][15:0];
            w_o_val[l] = w_plane[NP][l].quad[1] ? -$signed(w_o_mag[l]) : $signed(w_o_mag[l]);
            if (w_pside[NP].err) begin
                w_o_val[l] = 16'sd0;
            end
        end
    end

    // Output register with a one-item skid buffer.
    logic               r_out_valid;
    logic               r_skid_full;
    logic signed [15:0] r_out_sin, r_out_cos, r_skid_sin, r_skid_cos;
    logic               r_out_err, r_skid_err;
    logic               w_produce, w_take;

    assign w_en      = !r_skid_full;
    assign w_produce = w_pv[NP] && w_en;
    assign w_take    = r_out_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_skid_full <= 1'b0;
        end else begin
            if (w_produce) begin
                if (!r_out_valid || w_take) begin
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid_full <= 1'b1;
                end
            end else if (w_take) begin
                // Refill from the skid buffer, or drop to empty.
                r_out_valid <= r_skid_full;
                r_skid_full <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_produce) begin
            if (!r_out_valid || w_take) begin
                r_out_sin <= w_o_val[0];
                r_out_cos <= w_o_val[1];
                r_out_err <= w_pside[NP].err;
            end else begin
                r_skid_sin <= w_o_val[0];
                r_skid_cos <= w_o_val[1];
                r_skid_err <= w_pside[NP].err;
            end
        end else if (w_take && r_skid_full) begin
            r_out_sin <= r_skid_sin;
            r_out_cos <= r_skid_cos;
            r_out_err <= r_skid_err;
        end
    end

    assign o_ready       = w_en;
    assign o_valid       = r_out_valid;
    assign o_sin_value   = r_out_sin;
    assign o_cos_value   = r_out_cos;
    assign o_index_error = r_out_err;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_full |-> r_out_valid)
        else $error("skid buffer full with output register empty");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_err) |-> (r_out_sin == 16'sd0 && r_out_cos == 16'sd0))
        else $error("index error item carries nonzero values");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_full && i_ready) |=> !r_skid_full)
        else $error("skid buffer not drained after output taken");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_full && !i_ready) |=> (r_skid_full && $stable(r_skid_sin)))
        else $error("skid buffer lost its item during a stall");
endmodule
`default_nettype wire

// File: tb/testbench.sv
// Self-checking testbench of the sinusoidal position encoder.
`timescale 1ns / 1ps
`default_nettype none
module testbench;

    typedef struct {
        logic [15:0] position;
        logic [10:0] pair_index;
    } t_token;

    typedef struct {
        logic [15:0] sin_value;
        logic [15:0] cos_value;
        logic        index_error;
    } t_encoding;

    localparam int LATENCY     = 89;
    localparam int CYCLE_LIMIT = 400000;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic [15:0]        i_position;
    logic [10:0]        i_pair_index;
    logic               o_valid;
    logic               i_ready;
    logic signed [15:0] o_sin_value;
    logic signed [15:0] o_cos_value;
    logic               o_index_error;
    logic               i_cfg_we;
    logic [11:0]        i_cfg_data;

    t_token    pending_tokens[$];
    t_encoding expected_encodings[$];
    logic [11:0] model_half_dim;
    int errors;
    int cycle_count;
    bit send_idle_on;
    bit recv_idle_on;
    int send_gap;
    int recv_gap;
    logic o_ready_seen;

    sinusoidal_position_encoder i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_position(i_position), .i_pair_index(i_pair_index),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_sin_value(o_sin_value), .o_cos_value(o_cos_value),
        .o_index_error(o_index_error),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic [63:0] int_sqrt(input logic [63:0] val);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] b;
        v   = val;
        res = 0;
        b   = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v   = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic longint scale_q30(input longint a, input logic [63:0] b);
        logic [63:0] m;
        if (a < 0) begin
            m = (64'(-a) * b) >> 30;
            return -longint'(m);
        end
        m = (64'(a) * b) >> 30;
        return longint'(m);
    endfunction

    function automatic logic [15:0] sine_of_phase(input logic [31:0] u);
        logic [1:0]  quad;
        logic [63:0] z;
        logic [63:0] z2;
        longint acc;
        longint v;
        quad = u[31:30];
        z    = {34'd0, u[29:0]};
        if (quad[0]) z = 64'(spe_pkg::ONE_Q30) - z;
        z2  = (z * z) >> 30;
        acc = 172265;
        acc = -5026782 + scale_q30(acc, z2);
        acc = 85569306 + scale_q30(acc, z2);
        acc = -693598668 + scale_q30(acc, z2);
        acc = 1686629713 + scale_q30(acc, z2);
        acc = scale_q30(acc, z);
        if (acc < 0) acc = 0;
        v = (acc + (longint'(1) << (spe_pkg::RND_SH - 1))) >>> spe_pkg::RND_SH;
        if (v > longint'(spe_pkg::OUT_MAX)) v = longint'(spe_pkg::OUT_MAX);
        if (quad[1]) v = -v;
        return v[15:0];
    endfunction

    function automatic t_encoding encode_token(input t_token t, input logic [11:0] hd);
        t_encoding e;
        logic [63:0] h, k, r, x, n, f, p, c, a, q, u;
        h = hd;
        if (h > spe_pkg::MAX_DIM / 2) h = spe_pkg::MAX_DIM / 2;
        k = t.pair_index;
        if (k >= h) begin
            e.sin_value = 0;
            e.cos_value = 0;
            e.index_error = 1'b1;
            return e;
        end
        r = (k << 32) / h;
        x = r * 13 + ((r * 64'd1235715261) >> 32);
        n = x >> 32;
        f = x & 64'hFFFF_FFFF;
        p = 64'd1 << 32;
        c = 64'd1 << 31;
        for (int i = 1; i <= 32; i++) begin
            c = int_sqrt(c << 32);
            if (f[32 - i]) p = (p * c) >> 32;
        end
        a = (64'(t.position) * p) >> n[5:0];
        q = a % spe_pkg::TWO_PI_Q32;
        u = (((q >> 3) * 64'd683565276) >> 29) & 64'hFFFF_FFFF;
        e.sin_value = sine_of_phase(u[31:0]);
        e.cos_value = sine_of_phase(u[31:0] + spe_pkg::ONE_Q30);
        e.index_error = 1'b0;
        return e;
    endfunction

    task automatic add_token(input logic [15:0] pos, input logic [10:0] k);
        t_token t;
        t.position   = pos;
        t.pair_index = k;
        pending_tokens.push_back(t);
    endtask

    task automatic add_random_tokens(input int count, input logic [11:0] hd);
        logic [15:0] pos;
        logic [10:0] k;
        for (int i = 0; i < count; i++) begin
            pos = (($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 255))
                                                : 16'($urandom));
            if ($urandom_range(0, 7) == 0 || hd == 0) k = 11'($urandom);
            else k = 11'($urandom_range(0, (hd > 2048 ? 2048 : hd) - 1));
            add_token(pos, k);
        end
    endtask

    // Wait for the block to drain, then let the pipeline settle before a write.
    task automatic drain_block();
        wait (pending_tokens.size() == 0 && !i_valid && expected_encodings.size() == 0);
        repeat (LATENCY + 4) @(negedge i_clk);
    endtask

    task automatic write_half_dim(input logic [11:0] value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        model_half_dim = value;
    endtask

    // Driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready_seen) begin
                // accepted at the last rising edge
            end
            if (!i_valid || o_ready_seen) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    i_valid <= 1'b0;
                end else if (pending_tokens.size() > 0) begin
                    i_valid      <= 1'b1;
                    i_position   <= pending_tokens[0].position;
                    i_pair_index <= pending_tokens[0].pair_index;
                    pending_tokens.pop_front();
                    if (send_idle_on && $urandom_range(0, 9) == 0)
                        send_gap <= $urandom_range(1, 15);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Capture acceptance at the rising edge; predict on acceptance.
    always @(posedge i_clk) begin
        o_ready_seen <= 1'b0;
        if (i_rst_n && i_valid && o_ready) begin
            t_token t;
            t.position   = i_position;
            t.pair_index = i_pair_index;
            expected_encodings.push_back(encode_token(t, model_half_dim));
            o_ready_seen <= 1'b1;
        end
    end

    // Monitor
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_encodings.size() == 0) begin
                $error("unexpected result");
                errors++;
            end else begin
                t_encoding e;
                e = expected_encodings.pop_front();
                if (o_sin_value !== e.sin_value) begin
                    $error("sin_value expected %0d actual %0d",
                           $signed(e.sin_value), o_sin_value);
                    errors++;
                end
                if (o_cos_value !== e.cos_value) begin
                    $error("cos_value expected %0d actual %0d",
                           $signed(e.cos_value), o_cos_value);
                    errors++;
                end
                if (o_index_error !== e.index_error) begin
                    $error("index_error expected %0b actual %0b",
                           e.index_error, o_index_error);
                    errors++;
                end
            end
        end
    end

    // Receiver stalls
    always @(negedge i_clk) begin
        if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            i_ready <= 1'b0;
        end else if (recv_idle_on && $urandom_range(0, 9) == 0) begin
            recv_gap <= $urandom_range(0, 14);
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    initial begin
        logic [11:0] settings[5];
        errors         = 0;
        cycle_count    = 0;
        send_gap       = 0;
        recv_gap       = 0;
        send_idle_on   = 1'b1;
        recv_idle_on   = 1'b1;
        model_half_dim = spe_pkg::HALF_DIM_RESET;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_ready      = 1'b0;
        i_position   = 0;
        i_pair_index = 0;
        i_cfg_we     = 1'b0;
        i_cfg_data   = 0;
        o_ready_seen = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed items on the reset setting
        add_token(16'd0, 11'd0);
        add_token(16'hFFFF, 11'd0);
        add_token(16'hFFFF, 11'd255);
        add_token(16'd1, 11'd0);
        add_token(16'h5555, 11'h2AA);
        add_token(16'hAAAA, 11'h055);
        add_token(16'd12345, 11'd256);
        add_token(16'd100, 11'h7FF);
        add_token(16'd3, 11'd128);
        add_random_tokens(250, spe_pkg::HALF_DIM_RESET);
        drain_block();

        settings[0] = 12'd2048;
        settings[1] = 12'd1;
        settings[2] = 12'hFFF;
        settings[3] = 12'd0;
        settings[4] = 12'd37;
        foreach (settings[i]) begin
            write_half_dim(settings[i]);
            add_token(16'hFFFF, 11'h7FF);
            add_token(16'h0000, 11'd0);
            add_token(16'd777, 11'd1);
            if (i == 4) begin
                send_idle_on = 1'b0;
                recv_idle_on = 1'b0;
            end
            add_random_tokens(i == 3 ? 40 : 120, settings[i]);
            drain_block();
        end

        wait (pending_tokens.size() == 0 && !i_valid && expected_encodings.size() == 0);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
`default_nettype wire

// File: filelist.f
sv/spe_pkg.sv
sv/spe_div_cell.sv
sv/spe_exp_cell.sv
sv/spe_mod_cell.sv
sv/spe_poly_cell.sv
sv/sinusoidal_position_encoder.sv
tb/testbench.sv
